// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the port checker (qau_checker.sv)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define QAU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define QAU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/qau_pkg.sv =====
`timescale 1ns / 1ps
package qau_pkg;

   typedef enum logic [2:0] {
      OP_MUL  = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_CONJ = 3'd3,
      OP_NORM = 3'd4
   } op_type;

   // scaled magnitude width used by normalize: largest lies in [2^29, 2^30]
   localparam int unsigned UW = 31;
   // sum of four squares of UW-bit values
   localparam int unsigned SW = 64;
   // square root width
   localparam int unsigned MW = 32;

   // side-band status that travels down the pipeline
   typedef struct packed {
      logic [2:0] op;
      logic       zero;
      logic       sat;
   } ctl_type;

endpackage

// ===== hw/rtl/qau_isqrt.sv =====
`timescale 1ns / 1ps
// pipelined integer square root, one result bit per stage, with a payload
module qau_isqrt
   import qau_pkg::*;
#(
   parameter int unsigned PW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [SW-1:0]     s,
   input  logic [PW-1:0]     pin,
   output logic [MW-1:0]     root,
   output logic [PW-1:0]     pout
);

   localparam int unsigned NS = MW;

   logic [SW-1:0]   rem_ff  [NS+1];
   logic [MW-1:0]   res_ff  [NS+1];
   logic [PW-1:0]   pay_ff  [NS+1];

   always_comb begin
      rem_ff[0] = s;
      res_ff[0] = '0;
      pay_ff[0] = pin;
   end

   for (genvar i = 0; i < NS; i++) begin : g_st
      localparam int unsigned SH = 2 * (NS - 1 - i);
      logic [SW+1:0] trial;
      logic [SW+1:0] remx;
      logic [SW-1:0] rem_in;
      logic [MW-1:0] res_in;
      logic [SW-1:0] rem_q;
      logic [MW-1:0] res_q;
      logic [PW-1:0] pay_q;
      always_comb begin
         // trial = (4*res + 1) << SH
         trial = (({{(SW+2-MW){1'b0}}, res_ff[i]} << 2) | (SW+2)'(1)) << SH;
         remx  = {2'b00, rem_ff[i]};
         if (remx >= trial) begin
            rem_in = SW'(remx - trial);
            res_in = {res_ff[i][MW-2:0], 1'b1};
         end else begin
            rem_in = rem_ff[i];
            res_in = {res_ff[i][MW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_q <= rem_in;
            res_q <= res_in;
            pay_q <= pay_ff[i];
         end
      end
      always_comb begin
         rem_ff[i+1] = rem_q;
         res_ff[i+1] = res_q;
         pay_ff[i+1] = pay_q;
      end
   end

   assign root = res_ff[NS];
   assign pout = pay_ff[NS];

   logic unused_rst;
   assign unused_rst = reset;

endmodule

// ===== hw/rtl/qau_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, with a payload
module qau_div
   import qau_pkg::*;
#(
   parameter int unsigned NW = 48,
   parameter int unsigned QW = 32,
   parameter int unsigned PW = 8
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [NW-1:0] num,
   input  logic [MW-1:0] den,
   input  logic [PW-1:0] pin,
   output logic [QW-1:0] quo,
   output logic [PW-1:0] pout
);

   // quotient known to fit QW bits: numerator < den << QW
   logic [NW-1:0] n_s [QW+1];
   logic [QW-1:0] q_s [QW+1];
   logic [MW-1:0] d_s [QW+1];
   logic [PW-1:0] p_s [QW+1];

   always_comb begin
      n_s[0] = num;
      q_s[0] = '0;
      d_s[0] = den;
      p_s[0] = pin;
   end

   for (genvar i = 0; i < QW; i++) begin : g_st
      localparam int unsigned SH = QW - 1 - i;
      logic [NW+QW:0] dsh;
      logic [NW-1:0]  n_in;
      logic           bit_in;
      logic [NW-1:0]  n_q;
      logic [QW-1:0]  q_q;
      logic [MW-1:0]  d_q;
      logic [PW-1:0]  p_q;
      always_comb begin
         dsh = {{(NW+QW+1-MW){1'b0}}, d_s[i]} << SH;
         if ({{(QW+1){1'b0}}, n_s[i]} >= dsh) begin
            n_in   = NW'({{(QW+1){1'b0}}, n_s[i]} - dsh);
            bit_in = 1'b1;
         end else begin
            n_in   = n_s[i];
            bit_in = 1'b0;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            n_q <= n_in;
            q_q <= q_s[i] | (QW'(bit_in) << SH);
            d_q <= d_s[i];
            p_q <= p_s[i];
         end
      end
      always_comb begin
         n_s[i+1] = n_q;
         q_s[i+1] = q_q;
         d_s[i+1] = d_q;
         p_s[i+1] = p_q;
      end
   end

   assign quo  = q_s[QW];
   assign pout = p_s[QW];

endmodule

// ===== hw/rtl/quaternion_arith_unit_core.sv =====
`timescale 1ns / 1ps
// quaternion arithmetic unit
// req channel: op plus quaternions a and b, valid/ready; rsp channel: one
// result quaternion r with saturated and zero_norm flags, valid/ready.
// ops: 0 hamilton product, 1 add, 2 subtract, 3 conjugate a, 4 normalize a;
// other codes give zero. components are signed fixed point, FRAC_BITS fraction.
// one transaction is accepted per cycle unless stalled; the whole datapath is a
// single lockstep pipeline of LAT = COMP_WIDTH + 37 stages (53 by default)
// set by the pipelined square root (32 stages) and divider stages (COMP_WIDTH+1
// quotient bits for normalize), plus 4 front stages (input register, abs/scale,
// squares and hamilton products, sums and rounding).
// the whole pipeline freezes, and req_ready falls, only when the final stage
// holds a result that is not being taken (rsp_ready low), so no transaction is
// lost or repeated. reset (synchronous, active high) clears the valid bits.
module quaternion_arith_unit_core
   import qau_pkg::*;
#(
   parameter int unsigned COMP_WIDTH = 16,
   parameter int unsigned FRAC_BITS  = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_op,
   input  logic signed [COMP_WIDTH-1:0] req_a_w,
   input  logic signed [COMP_WIDTH-1:0] req_a_x,
   input  logic signed [COMP_WIDTH-1:0] req_a_y,
   input  logic signed [COMP_WIDTH-1:0] req_a_z,
   input  logic signed [COMP_WIDTH-1:0] req_b_w,
   input  logic signed [COMP_WIDTH-1:0] req_b_x,
   input  logic signed [COMP_WIDTH-1:0] req_b_y,
   input  logic signed [COMP_WIDTH-1:0] req_b_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COMP_WIDTH-1:0] rsp_r_w,
   output logic signed [COMP_WIDTH-1:0] rsp_r_x,
   output logic signed [COMP_WIDTH-1:0] rsp_r_y,
   output logic signed [COMP_WIDTH-1:0] rsp_r_z,
   output logic                         rsp_saturated,
   output logic                         rsp_zero_norm
);

   localparam int unsigned CW  = COMP_WIDTH;
   localparam int unsigned PWD = 2 * CW;        // full product width
   localparam int unsigned RW  = PWD + 3;       // sum of four products
   localparam int unsigned QW  = CW + 1;        // normalize quotient bits
   localparam int unsigned NW  = UW + FRAC_BITS + 1;
   localparam int unsigned DL  = MW + QW;       // delay of the sqrt+div path
   localparam int unsigned LAT = 4 + DL;
   localparam int unsigned LW  = $clog2(UW + 1);
   localparam int unsigned PLD = 4 * CW + $bits(ctl_type) + 4 + 4 * UW;

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   // pipeline control: freeze everything when the last stage is stuck
   logic adv;
   logic [LAT-1:0] vld_ff;
   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // saturation helper on a wide signed value
   function automatic logic [CW:0] sat_w(input logic signed [RW-1:0] v);
      logic [CW:0] r;
      if (v > RW'(CMAX)) r = {1'b1, CMAX};
      else if (v < RW'(CMIN)) r = {1'b1, CMIN};
      else r = {1'b0, v[CW-1:0]};
      return r;
   endfunction

   // ---------------- stages 1 and 2: register inputs, magnitudes, leading zeros
   logic [2:0]          op1_ff;
   logic signed [CW-1:0] a1_ff [4];
   logic signed [CW-1:0] b1_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff   <= req_op;
         a1_ff[0] <= req_a_w; a1_ff[1] <= req_a_x;
         a1_ff[2] <= req_a_y; a1_ff[3] <= req_a_z;
         b1_ff[0] <= req_b_w; b1_ff[1] <= req_b_x;
         b1_ff[2] <= req_b_y; b1_ff[3] <= req_b_z;
      end
   end

   // magnitudes and block scaling (widths up to 32 so |a| <= 2^31)
   logic [CW:0]   mag [4];
   logic [CW:0]   mx;
   logic [LW-1:0] lsh;
   logic          rsh;
   always_comb begin
      mx = '0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = a1_ff[i][CW-1] ? (CW+1)'(-{a1_ff[i][CW-1], a1_ff[i]})
                                 : {1'b0, a1_ff[i]};
         if (mag[i] > mx) mx = mag[i];
      end
      lsh = '0;
      rsh = 1'b0;
      if ((CW + 1) > 31 && 64'(mx) > 64'(1 << 30)) begin
         rsh = 1'b1;
      end else begin
         for (int k = UW - 1; k >= 0; k--) begin
            if ((64'(mx) << k) >= 64'(1 << 29) && (64'(mx) << k) < 64'(1 << 30)) lsh = LW'(k);
            if ((64'(mx) << k) == 64'(1 << 30) && lsh == '0) lsh = LW'(k);
         end
      end
   end

   logic [UW-1:0] u2_ff [4];
   logic [2:0]    op2_ff;
   logic [3:0]    neg2_ff;
   logic          zero2_ff;
   logic signed [CW-1:0] a2_ff [4];
   logic signed [CW-1:0] b2_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         op2_ff   <= op1_ff;
         zero2_ff <= (mx == '0);
         for (int i = 0; i < 4; i++) begin
            u2_ff[i]   <= rsh ? UW'(64'(mag[i]) >> 1) : UW'(64'(mag[i]) << lsh);
            neg2_ff[i] <= a1_ff[i][CW-1];
            a2_ff[i]   <= a1_ff[i];
            b2_ff[i]   <= b1_ff[i];
         end
      end
   end

   // ---------------- stage 3: squares and hamilton products, one multiply each
   logic [SW-1:0] sq3_ff [4];
   logic signed [PWD-1:0] p3_ff [16];
   logic [UW-1:0] u3_ff [4];
   logic [2:0]    op3_ff;
   logic [3:0]    neg3_ff;
   logic          zero3_ff;
   logic signed [CW-1:0] a3_ff [4];
   logic signed [CW-1:0] b3_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            sq3_ff[i] <= SW'(u2_ff[i]) * SW'(u2_ff[i]);
            for (int j = 0; j < 4; j++)
               p3_ff[4*i+j] <= PWD'(a2_ff[i] * b2_ff[j]);
         end
         u3_ff    <= u2_ff;
         op3_ff   <= op2_ff;
         neg3_ff  <= neg2_ff;
         zero3_ff <= zero2_ff;
         a3_ff    <= a2_ff;
         b3_ff    <= b2_ff;
      end
   end

   // ---------------- stage 4: sums, rounding, saturation of the short ops
   function automatic logic signed [RW-1:0] sx(input logic signed [PWD-1:0] p);
      return RW'(p);
   endfunction

   logic signed [RW-1:0] hs [4];
   logic signed [RW-1:0] ew [4];
   logic [CW:0]          sr [4];
   logic signed [CW-1:0] rq [4];
   logic                 sq;
   always_comb begin
      // p index: 4*a_index + b_index, order w x y z
      hs[0] = sx(p3_ff[0])  - sx(p3_ff[5])  - sx(p3_ff[10]) - sx(p3_ff[15]);
      hs[1] = sx(p3_ff[1])  + sx(p3_ff[4])  + sx(p3_ff[11]) - sx(p3_ff[14]);
      hs[2] = sx(p3_ff[2])  + sx(p3_ff[8])  + sx(p3_ff[13]) - sx(p3_ff[7]);
      hs[3] = sx(p3_ff[3])  + sx(p3_ff[12]) + sx(p3_ff[6])  - sx(p3_ff[9]);
      sq = 1'b0;
      for (int i = 0; i < 4; i++) begin
         ew[i] = '0;
         unique case (op3_ff)
            OP_MUL:  ew[i] = (hs[i] + RW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
            OP_ADD:  ew[i] = RW'(a3_ff[i]) + RW'(b3_ff[i]);
            OP_SUB:  ew[i] = RW'(a3_ff[i]) - RW'(b3_ff[i]);
            OP_CONJ: ew[i] = (i == 0) ? RW'(a3_ff[i]) : -RW'(a3_ff[i]);
            default: ew[i] = '0;
         endcase
         sr[i] = sat_w(ew[i]);
         rq[i] = sr[i][CW-1:0];
         sq    = sq | sr[i][CW];
      end
   end

   // sum of squares is at most 4*2^60
   logic [SW-1:0] ssum;
   assign ssum = sq3_ff[0] + sq3_ff[1] + sq3_ff[2] + sq3_ff[3];

   // payload carried beside the sqrt and divider
   logic [PLD-1:0] pl_in;
   logic [PLD-1:0] pl_root;
   logic [PLD-1:0] pl_out;
   ctl_type        c_in;
   always_comb begin
      c_in.op   = op3_ff;
      c_in.zero = zero3_ff;
      c_in.sat  = sq;
      pl_in = {rq[0], rq[1], rq[2], rq[3], c_in, neg3_ff,
               u3_ff[0], u3_ff[1], u3_ff[2], u3_ff[3]};
   end

   logic [SW-1:0]  s4_ff;
   logic [PLD-1:0] pl4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ff  <= ssum;
         pl4_ff <= pl_in;
      end
   end

   logic [MW-1:0] root;
   qau_isqrt #(.PW(PLD)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .s     (s4_ff),
      .pin   (pl4_ff),
      .root  (root),
      .pout  (pl_root)
   );

   // four dividers share the root; u_i << F + m/2 over m; quotient < 2^QW
   logic [UW-1:0] ur [4];
   assign {ur[0], ur[1], ur[2], ur[3]} = pl_root[4*UW-1:0];

   logic [MW-1:0] den;
   assign den = (root == '0) ? MW'(1) : root;

   logic [QW-1:0] qo [4];
   logic [PLD-1:0] pl_d [4];
   for (genvar g = 0; g < 4; g++) begin : g_div
      logic [NW-1:0] num;
      assign num = (NW'(ur[g]) << FRAC_BITS) + NW'(root >> 1);
      qau_div #(.NW(NW), .QW(QW), .PW(PLD)) u_div (
         .clock (clock),
         .adv   (adv),
         .num   (num),
         .den   (den),
         .pin   (pl_root),
         .quo   (qo[g]),
         .pout  (pl_d[g])
      );
   end
   assign pl_out = pl_d[0];

   // ---------------- output select
   logic signed [CW-1:0] oq [4];
   ctl_type              co;
   logic [3:0]           on;
   assign {oq[0], oq[1], oq[2], oq[3], co, on} = pl_out[PLD-1:4*UW];

   logic signed [CW-1:0] rf [4];
   logic                 fsat;
   logic [CW:0]          ns [4];
   logic signed [RW-1:0] nv;
   always_comb begin
      fsat = co.sat;
      for (int i = 0; i < 4; i++) begin
         nv    = on[i] ? -RW'(qo[i]) : RW'(qo[i]);
         ns[i] = sat_w(nv);
         rf[i] = oq[i];
      end
      if (co.op == OP_NORM) begin
         fsat = 1'b0;
         if (co.zero) begin
            ns[0] = sat_w(RW'(1) <<< FRAC_BITS);
            ns[1] = '0; ns[2] = '0; ns[3] = '0;
         end
         for (int i = 0; i < 4; i++) begin
            rf[i] = ns[i][CW-1:0];
            fsat  = fsat | ns[i][CW];
         end
      end
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_r_w       = rf[0];
   assign rsp_r_x       = rf[1];
   assign rsp_r_y       = rf[2];
   assign rsp_r_z       = rf[3];
   assign rsp_saturated = fsat;
   assign rsp_zero_norm = (co.op == OP_NORM) && co.zero;

endmodule

// ===== hw/rtl/qau_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// port-level checks for the quaternion unit
module qau_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_saturated,
   input logic rsp_zero_norm,
   input logic [15:0] rsp_r_w
);

   `QAU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `QAU_ASSERT(a_ready_free, clock, reset, !rsp_valid |-> req_ready, "stalled while empty")
   `QAU_ASSERT(a_zero_id, clock, reset, rsp_valid && rsp_zero_norm |-> rsp_r_w != 16'h0, "bad identity")
   `QAU_ASSERT(a_reset, clock, reset, $past(reset) |-> !rsp_valid, "valid after reset")

   logic unused;
   assign unused = req_valid ^ rsp_saturated;

endmodule

bind quaternion_arith_unit_core qau_checker u_qau_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_saturated (rsp_saturated),
   .rsp_zero_norm (rsp_zero_norm),
   .rsp_r_w       (rsp_r_w[15:0])
);

// ===== tb/quat_checker.sv =====
`timescale 1ns / 1ps
module quat_checker
   import qau_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic signed [15:0] req_a_w,
   input  logic signed [15:0] req_a_x,
   input  logic signed [15:0] req_a_y,
   input  logic signed [15:0] req_a_z,
   input  logic signed [15:0] req_b_w,
   input  logic signed [15:0] req_b_x,
   input  logic signed [15:0] req_b_y,
   input  logic signed [15:0] req_b_z,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_r_w,
   input  logic signed [15:0] rsp_r_x,
   input  logic signed [15:0] rsp_r_y,
   input  logic signed [15:0] rsp_r_z,
   input  logic               rsp_saturated,
   input  logic               rsp_zero_norm,
   output int                 fail_count,
   output int                 pending_count
);

   localparam int FRAC = 14;
   localparam longint CMAX = 32767;
   localparam longint CMIN = -32768;

   typedef struct packed {
      logic signed [15:0] w, x, y, z;
      logic               saturated;
      logic               zero_norm;
   } quat_result_type;

   quat_result_type result_q[$];

   function automatic longint clip(input longint v, inout bit flag);
      if (v > CMAX) begin
         flag = 1;
         return CMAX;
      end
      if (v < CMIN) begin
         flag = 1;
         return CMIN;
      end
      return v;
   endfunction

   // exact sum, then round half up; >>> on 64 bits is a floor
   function automatic longint round_q(input longint s);
      return (s + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint int_sqrt(input longint unsigned s);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic quat_result_type compute_quat(input logic [2:0] op,
                                                    input longint a[4], input longint b[4]);
      quat_result_type res;
      longint r[4];
      longint unsigned u[4], mx, s, m, q;
      bit sf, zf;
      sf = 0;
      zf = 0;
      for (int i = 0; i < 4; i++) r[i] = 0;
      case (op)
         OP_MUL: begin
            r[0] = clip(round_q(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]), sf);
            r[1] = clip(round_q(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]), sf);
            r[2] = clip(round_q(a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3]), sf);
            r[3] = clip(round_q(a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1]), sf);
         end
         OP_ADD: for (int i = 0; i < 4; i++) r[i] = clip(a[i] + b[i], sf);
         OP_SUB: for (int i = 0; i < 4; i++) r[i] = clip(a[i] - b[i], sf);
         OP_CONJ: begin
            r[0] = a[0];
            for (int i = 1; i < 4; i++) r[i] = clip(-a[i], sf);
         end
         OP_NORM: begin
            mx = 0;
            for (int i = 0; i < 4; i++) begin
               u[i] = (a[i] < 0) ? -a[i] : a[i];
               if (u[i] > mx) mx = u[i];
            end
            if (mx == 0) begin
               zf = 1;
               r[0] = clip(64'sd1 <<< FRAC, sf);
            end else begin
               // block scaling so the largest magnitude sits in [2^29, 2^30]
               while (mx < (64'd1 << 29)) begin
                  mx <<= 1;
                  for (int i = 0; i < 4; i++) u[i] <<= 1;
               end
               s = 0;
               for (int i = 0; i < 4; i++) s += u[i] * u[i];
               m = int_sqrt(s);
               for (int i = 0; i < 4; i++) begin
                  q = ((u[i] << FRAC) + (m >> 1)) / m;
                  r[i] = clip(a[i] < 0 ? -longint'(q) : longint'(q), sf);
               end
            end
         end
         default: ;
      endcase
      res.w = 16'(r[0]);
      res.x = 16'(r[1]);
      res.y = 16'(r[2]);
      res.z = 16'(r[3]);
      res.saturated = sf;
      res.zero_norm = zf;
      return res;
   endfunction

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      longint a[4], b[4];
      quat_result_type exp_r;
      if (!reset) begin
         if (req_valid && req_ready) begin
            a = '{req_a_w, req_a_x, req_a_y, req_a_z};
            b = '{req_b_w, req_b_x, req_b_y, req_b_z};
            result_q.push_back(compute_quat(req_op, a, b));
         end
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual r_w=%0d",
                        $time, rsp_r_w);
               fail_count++;
            end else begin
               exp_r = result_q.pop_front();
               check_field("r_w", exp_r.w, rsp_r_w);
               check_field("r_x", exp_r.x, rsp_r_x);
               check_field("r_y", exp_r.y, rsp_r_y);
               check_field("r_z", exp_r.z, rsp_r_z);
               check_field("saturated", exp_r.saturated, rsp_saturated);
               check_field("zero_norm", exp_r.zero_norm, rsp_zero_norm);
            end
         end
         pending_count = result_q.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import qau_pkg::*;

   localparam int LAT = 53;
   localparam int NUM_RANDOM = 1000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_op = OP_MUL;
   logic signed [15:0] req_a_w = 0, req_a_x = 0, req_a_y = 0, req_a_z = 0;
   logic signed [15:0] req_b_w = 0, req_b_x = 0, req_b_y = 0, req_b_z = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z;
   logic rsp_saturated, rsp_zero_norm;
   int fail_count, pending_count;
   bit stim_done = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   quaternion_arith_unit_core u_dut (.*);

   quat_checker u_chk (.*);

   // no gap half the time, else mostly a short one and now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random component that leans on the corners of the range
   function automatic logic signed [15:0] pick_comp();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 0;
         3: return 16'sh4000;
         4: return 16'shc000;
         5: return 16'($urandom_range(0, 7) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // one transaction: hold valid and payload until accepted
   task automatic send_quat(input logic [2:0] op, input logic signed [15:0] aw, ax, ay, az,
                            input logic signed [15:0] bw, bx, by, bz);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      {req_a_w, req_a_x, req_a_y, req_a_z} <= {aw, ax, ay, az};
      {req_b_w, req_b_x, req_b_y, req_b_z} <= {bw, bx, by, bz};
      do @(posedge clock); while (!req_ready);
   endtask

   // receiver side stalls at random, with stretches of always-ready
   initial begin
      int burst;
      int gap;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            burst = $urandom_range(20, 100);
            rsp_ready <= 1;
            repeat (burst) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [2:0] op;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners
      send_quat(OP_MUL, 16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0);
      send_quat(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_quat(OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_quat(OP_MUL, 1, 1, 0, 0, 16'sh2000, 16'sh2000, 0, 0);
      send_quat(OP_MUL, 0, 16'sh4000, 0, 0, 0, 0, 16'sh4000, 0);
      send_quat(OP_ADD, 16'sh7fff, 16'sh8000, 1, -1, 1, -1, 16'sh7fff, 16'sh8000);
      send_quat(OP_ADD, 16'sh8000, 16'sh8000, 0, 0, 16'sh8000, 0, 0, 0);
      send_quat(OP_SUB, 16'sh8000, 16'sh7fff, 0, 5, 1, -1, 16'sh8000, 5);
      send_quat(OP_SUB, 0, 0, 0, 0, 16'sh8000, 16'sh7fff, 1, 0);
      send_quat(OP_CONJ, 16'sh8000, 16'sh8000, 16'sh7fff, 0, 3, 3, 3, 3);
      send_quat(OP_CONJ, 16'sh7fff, 1, -1, 16'sh8000, 0, 0, 0, 0);
      send_quat(OP_NORM, 0, 0, 0, 0, 16'sh1234, 1, 2, 3);
      send_quat(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
      send_quat(OP_NORM, 0, 0, 0, -1, 0, 0, 0, 0);
      send_quat(OP_NORM, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
      send_quat(OP_NORM, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
      send_quat(OP_NORM, 16'sh8000, 0, 0, 0, 0, 0, 0, 0);
      send_quat(OP_NORM, 3, 4, 0, 0, 0, 0, 0, 0);
      send_quat(3'd5, 16'sh7fff, 1, 2, 3, 4, 5, 6, 7);
      send_quat(3'd6, 16'sh8000, 0, 0, 0, 0, 0, 0, 0);
      send_quat(3'd7, -1, -1, -1, -1, -1, -1, -1, -1);

      // random mix, mostly valid opcodes
      repeat (NUM_RANDOM) begin
         op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
         send_quat(op, pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                   pick_comp(), pick_comp(), pick_comp(), pick_comp());
      end
      req_valid <= 0;
      stim_done = 1;
   end

   // verdict once everything has drained
   initial begin
      wait (stim_done);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
      if (fail_count == 0)
         $display("quaternion_arith_unit_core test passed");
      else
         $display("quaternion_arith_unit_core test failed");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("quaternion_arith_unit_core test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/qau_pkg.sv
hw/rtl/qau_isqrt.sv
hw/rtl/qau_div.sv
hw/rtl/quaternion_arith_unit_core.sv
hw/rtl/qau_checker.sv
tb/quat_checker.sv
tb/tb_top.sv
